### src/wsfh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfh_pkg
// Types, codes and helper functions shared by the frame header parser.
// ----------------------------------------------------------------------------
package wsfh_pkg;

    // basic length codes that announce an extended length field
    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;
    localparam logic [6:0] CTRL_MAX   = 7'd125;

    // opcode boundaries for the reserved ranges
    localparam logic [3:0] OP_RSV_LO_FIRST  = 4'd3;
    localparam logic [3:0] OP_RSV_LO_LAST   = 4'd7;
    localparam logic [3:0] OP_RSV_HI_FIRST  = 4'd11;

    localparam logic [3:0] BASIC_HDR_LEN = 4'd2;
    localparam logic [3:0] LEN16_BYTES   = 4'd2;
    localparam logic [3:0] LEN64_BYTES   = 4'd8;
    localparam logic [3:0] KEY_BYTES     = 4'd4;

    typedef enum logic [1:0] {
        PH_BASIC,
        PH_EXT,
        PH_DONE,
        PH_ERR
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_CTRL_BIG  = 3'd1,
        ERR_RSV_BIT   = 3'd2,
        ERR_RSV_OP    = 3'd3,
        ERR_FRAG_CTRL = 3'd4,
        ERR_LEN_MIN   = 3'd5
    } t_err;

    // one input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_item;

    // one result request
    typedef struct packed {
        logic        header_done;
        logic [2:0]  error_code;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic        mask_present;
        logic [63:0] payload_length;
        logic [31:0] mask_key;
        logic [3:0]  header_length;
    } t_result;

    // number of extended length bytes announced by the second byte
    function automatic logic [3:0] ext_len_bytes(input logic [7:0] second);
        logic [3:0] n;
        if (second[6:0] == LEN16_CODE) begin
            n = LEN16_BYTES;
        end else if (second[6:0] == LEN64_CODE) begin
            n = LEN64_BYTES;
        end else begin
            n = 4'd0;
        end
        return n;
    endfunction

    // total header size implied by the second byte
    function automatic logic [3:0] total_len(input logic [7:0] second);
        return BASIC_HDR_LEN + ext_len_bytes(second) + (second[7] ? KEY_BYTES : 4'd0);
    endfunction

    // checks on the two basic bytes, first failing check wins
    function automatic t_err check_basic(input logic [7:0] first, input logic [7:0] second);
        logic [3:0] op;
        logic       ctrl;
        t_err       e;
        op   = first[3:0];
        ctrl = op[3];
        if (ctrl && (second[6:0] > CTRL_MAX)) begin
            e = ERR_CTRL_BIG;
        end else if (first[6:4] != 3'd0) begin
            e = ERR_RSV_BIT;
        end else if ((op >= OP_RSV_LO_FIRST && op <= OP_RSV_LO_LAST) ||
                     op >= OP_RSV_HI_FIRST) begin
            e = ERR_RSV_OP;
        end else if (ctrl && !first[7]) begin
            e = ERR_FRAG_CTRL;
        end else begin
            e = ERR_NONE;
        end
        return e;
    endfunction

endpackage

### src/wsfh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfh_in_if / wsfh_out_if
// Valid/ready channels carrying header bytes in and parse results out.
// ----------------------------------------------------------------------------
interface wsfh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface wsfh_out_if;
    logic        valid;
    logic        ready;
    logic        header_done;
    logic [2:0]  error_code;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        mask_present;
    logic [63:0] payload_length;
    logic [31:0] mask_key;
    logic [3:0]  header_length;

    modport source (
        output valid, output header_done, output error_code, output fin_flag,
        output frame_opcode, output mask_present, output payload_length,
        output mask_key, output header_length, input ready
    );
    modport sink (
        input valid, input header_done, input error_code, input fin_flag,
        input frame_opcode, input mask_present, input payload_length,
        input mask_key, input header_length, output ready
    );
endinterface

### src/wsfh_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfh_in_reg
// Input register: takes one input request per cycle while it has room.
// ----------------------------------------------------------------------------
module wsfh_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wsfh_in_if.sink         i_in,
    input  logic            i_take,
    output logic            o_valid,
    output wsfh_pkg::t_item o_item
);
    import wsfh_pkg::*;

    logic  r_valid;
    t_item r_item;

    // free slot, or the held request leaves this cycle
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.data_byte <= i_in.data_byte;
            r_item.restart   <= i_in.restart;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### src/wsfh_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfh_parse
// Parser state and the single-pass next-state / result logic for one byte.
// ----------------------------------------------------------------------------
module wsfh_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  wsfh_pkg::t_item   i_item,
    output wsfh_pkg::t_result o_result
);
    import wsfh_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_seen,   n_seen;
    logic [7:0]  r_first,  n_first;
    logic [7:0]  r_second, n_second;
    logic [63:0] r_len,    n_len;
    logic [31:0] r_key,    n_key;
    t_err        r_err,    n_err;

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BASIC;
            r_seen   <= 4'd0;
            r_first  <= 8'd0;
            r_second <= 8'd0;
            r_len    <= 64'd0;
            r_key    <= 32'd0;
            r_err    <= ERR_NONE;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_seen   <= n_seen;
            r_first  <= n_first;
            r_second <= n_second;
            r_len    <= n_len;
            r_key    <= n_key;
            r_err    <= n_err;
        end
    end

    // next state for one byte
    always_comb begin
        logic [7:0] b;
        logic       fin_now;
        logic       done;
        b       = i_item.data_byte;
        fin_now = 1'b0;

        // restart drops everything held so far
        if (i_item.restart) begin
            n_phase  = PH_BASIC;
            n_seen   = 4'd0;
            n_first  = 8'd0;
            n_second = 8'd0;
            n_len    = 64'd0;
            n_key    = 32'd0;
            n_err    = ERR_NONE;
        end else begin
            n_phase  = r_phase;
            n_seen   = r_seen;
            n_first  = r_first;
            n_second = r_second;
            n_len    = r_len;
            n_key    = r_key;
            n_err    = r_err;
        end

        unique case (n_phase)
            PH_BASIC: begin
                if (n_seen == 4'd0) begin
                    n_first = b;
                    n_seen  = 4'd1;
                end else begin
                    n_second = b;
                    n_seen   = 4'd2;
                    n_err    = check_basic(n_first, b);
                    if (n_err != ERR_NONE) begin
                        n_phase = PH_ERR;
                    end else if (total_len(b) > BASIC_HDR_LEN) begin
                        n_phase = PH_EXT;
                    end else begin
                        fin_now = 1'b1;
                    end
                end
            end
            PH_EXT: begin
                // length bytes first, key bytes after
                if (n_seen < BASIC_HDR_LEN + ext_len_bytes(n_second)) begin
                    n_len = {n_len[55:0], b};
                end else begin
                    n_key = {n_key[23:0], b};
                end
                n_seen = n_seen + 4'd1;
                if (n_seen >= total_len(n_second)) begin
                    fin_now = 1'b1;
                end
            end
            PH_DONE, PH_ERR: begin
                // bytes ignored until restart
            end
            default: begin
            end
        endcase

        // end of header: short length or minimal-encoding check
        if (fin_now) begin
            if (n_second[6:0] < LEN16_CODE) begin
                n_len = {57'd0, n_second[6:0]};
            end else if (n_second[6:0] == LEN16_CODE) begin
                if (n_len < {57'd0, LEN16_CODE}) begin
                    n_err = ERR_LEN_MIN;
                end
            end else begin
                if (n_len[63:16] == 48'd0) begin
                    n_err = ERR_LEN_MIN;
                end
            end
            n_phase = (n_err != ERR_NONE) ? PH_ERR : PH_DONE;
        end

        // result built from the state after this byte
        done = (n_phase == PH_DONE);
        o_result.header_done    = done;
        o_result.error_code     = n_err;
        o_result.fin_flag       = n_first[7];
        o_result.frame_opcode   = n_first[3:0];
        o_result.mask_present   = n_second[7];
        o_result.payload_length = done ? n_len : 64'd0;
        o_result.mask_key       = (done && n_second[7]) ? n_key : 32'd0;
        o_result.header_length  = total_len(n_second);
    end

endmodule

### src/wsfh_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfh_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module wsfh_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wsfh_pkg::t_result i_result,
    output logic              o_can_load,
    wsfh_out_if.source        o_out
);
    import wsfh_pkg::*;

    logic    r_valid;
    t_result r_result;

    // empty, or the held result is taken this cycle
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.header_done    = r_result.header_done;
    assign o_out.error_code     = r_result.error_code;
    assign o_out.fin_flag       = r_result.fin_flag;
    assign o_out.frame_opcode   = r_result.frame_opcode;
    assign o_out.mask_present   = r_result.mask_present;
    assign o_out.payload_length = r_result.payload_length;
    assign o_out.mask_key       = r_result.mask_key;
    assign o_out.header_length  = r_result.header_length;

endmodule

### src/websocket_frame_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_header_parser
// RFC 6455 frame header parser, one header byte per request.
// ----------------------------------------------------------------------------
// Each accepted byte gives exactly one result describing the header parsed
// so far. A byte with restart set starts a new header. The block takes one
// byte every cycle while the output is not stalled. A byte is held in the
// input register and its result in the result register, where it waits
// while the output is stalled, and the parse state is updated by one pass of
// logic between them. Errors and a completed header are held and repeated on
// every following byte until the next restart.
// ----------------------------------------------------------------------------
module websocket_frame_header_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsfh_in_if.sink    i_in,
    wsfh_out_if.source o_out
);
    import wsfh_pkg::*;

    logic    in_valid;
    t_item   in_item;
    logic    can_load;
    logic    take;
    t_result result;

    // a held byte moves on when the result register has room
    assign take = in_valid && can_load;

    wsfh_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    wsfh_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (take),
        .i_item   (in_item),
        .o_result (result)
    );

    wsfh_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_valid),
        .i_result   (result),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

### bench/wsfh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfh_checker
// Watches both channels of the frame header parser. It keeps its own copy of
// the parse state, works out the result that each accepted header byte must
// give, and compares every accepted result field by field with the oldest
// pending one. It hands the failure count and the number of results still
// owed to the testbench top.
// ----------------------------------------------------------------------------
module wsfh_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    wsfh_in_if   i_in_ch,
    wsfh_out_if  i_out_ch,
    output int   o_fail_count,
    output int   o_pending
);
    import wsfh_pkg::*;

    localparam int          MAX_SHOWN = 10;
    localparam logic [63:0] LEN16_MAX = 64'hFFFF;

    // shadow parse state
    t_phase      parse_phase;
    logic [3:0]  byte_count;
    logic [7:0]  hdr_byte0;
    logic [7:0]  hdr_byte1;
    logic [63:0] len_acc;
    logic [31:0] key_acc;
    t_err        err_held;

    t_result     owed_results[$];
    int          fail_total = 0;

    // extended length bytes announced by the length code of byte 1
    function automatic logic [3:0] ext_bytes_for(input logic [7:0] b1);
        case (b1[6:0])
            LEN16_CODE: return LEN16_BYTES;
            LEN64_CODE: return LEN64_BYTES;
            default:    return 4'd0;
        endcase
    endfunction

    function automatic logic [3:0] header_size(input logic [7:0] b1);
        return BASIC_HDR_LEN + ext_bytes_for(b1) + (b1[7] ? KEY_BYTES : 4'd0);
    endfunction

    // basic header checks, lowest code wins
    function automatic t_err basic_fault(input logic [7:0] b0, input logic [7:0] b1);
        logic [3:0] op;
        logic       is_ctrl;
        logic       bad_op;
        t_err       e;
        op      = b0[3:0];
        is_ctrl = op[3];
        bad_op  = (op >= OP_RSV_LO_FIRST && op <= OP_RSV_LO_LAST) ||
                  (op >= OP_RSV_HI_FIRST);
        e       = ERR_NONE;
        if (is_ctrl && b1[6:0] > CTRL_MAX) begin
            e = ERR_CTRL_BIG;
        end else if (b0[6:4] != 3'd0) begin
            e = ERR_RSV_BIT;
        end else if (bad_op) begin
            e = ERR_RSV_OP;
        end else if (is_ctrl && !b0[7]) begin
            e = ERR_FRAG_CTRL;
        end
        return e;
    endfunction

    task automatic clear_parser;
        parse_phase = PH_BASIC;
        byte_count  = 4'd0;
        hdr_byte0   = 8'd0;
        hdr_byte1   = 8'd0;
        len_acc     = 64'd0;
        key_acc     = 32'd0;
        err_held    = ERR_NONE;
    endtask

    // last header byte taken: settle the length and check its encoding
    task automatic close_header;
        logic [6:0] code;
        code = hdr_byte1[6:0];
        if (code < LEN16_CODE) begin
            len_acc = {57'd0, code};
        end else if (code == LEN16_CODE) begin
            if (len_acc < {57'd0, LEN16_CODE}) err_held = ERR_LEN_MIN;
        end else begin
            // top bit of a 64-bit length is left alone
            if (len_acc <= LEN16_MAX) err_held = ERR_LEN_MIN;
        end
        parse_phase = (err_held != ERR_NONE) ? PH_ERR : PH_DONE;
    endtask

    // one accepted byte: advance the shadow state, queue the result it owes
    task automatic take_byte(input logic [7:0] b, input logic rs);
        logic [3:0] idx;
        logic       done;
        t_result    r;
        if (rs) clear_parser();
        case (parse_phase)
            PH_BASIC: begin
                if (byte_count == 4'd0) begin
                    hdr_byte0  = b;
                    byte_count = 4'd1;
                end else begin
                    hdr_byte1  = b;
                    byte_count = 4'd2;
                    err_held   = basic_fault(hdr_byte0, hdr_byte1);
                    if (err_held != ERR_NONE) begin
                        parse_phase = PH_ERR;
                    end else if (header_size(hdr_byte1) > BASIC_HDR_LEN) begin
                        parse_phase = PH_EXT;
                    end else begin
                        close_header();
                    end
                end
            end
            PH_EXT: begin
                idx = byte_count;
                // length bytes first, then the key, both big-endian
                if (idx < BASIC_HDR_LEN + ext_bytes_for(hdr_byte1)) begin
                    len_acc = {len_acc[55:0], b};
                end else begin
                    key_acc = {key_acc[23:0], b};
                end
                byte_count = idx + 4'd1;
                if (idx + 4'd1 >= header_size(hdr_byte1)) close_header();
            end
            // done or failed: held until restart
            default: ;
        endcase

        done             = (parse_phase == PH_DONE);
        r.header_done    = done;
        r.error_code     = err_held;
        r.fin_flag       = hdr_byte0[7];
        r.frame_opcode   = hdr_byte0[3:0];
        r.mask_present   = hdr_byte1[7];
        r.payload_length = done ? len_acc : 64'd0;
        r.mask_key       = (done && hdr_byte1[7]) ? key_acc : 32'd0;
        r.header_length  = header_size(hdr_byte1);
        owed_results.push_back(r);
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            fail_total++;
            if (fail_total <= MAX_SHOWN)
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $realtime, field, want, got);
        end
    endtask

    task automatic check_result;
        t_result want;
        if (owed_results.size() == 0) begin
            fail_total++;
            if (fail_total <= MAX_SHOWN)
                $display("%0t: result with no request behind it", $realtime);
        end else begin
            want = owed_results.pop_front();
            compare_field("header_done", 64'(want.header_done),
                          64'(i_out_ch.header_done));
            compare_field("error_code", 64'(want.error_code),
                          64'(i_out_ch.error_code));
            compare_field("fin_flag", 64'(want.fin_flag), 64'(i_out_ch.fin_flag));
            compare_field("frame_opcode", 64'(want.frame_opcode),
                          64'(i_out_ch.frame_opcode));
            compare_field("mask_present", 64'(want.mask_present),
                          64'(i_out_ch.mask_present));
            compare_field("payload_length", want.payload_length, i_out_ch.payload_length);
            compare_field("mask_key", 64'(want.mask_key), 64'(i_out_ch.mask_key));
            compare_field("header_length", 64'(want.header_length),
                          64'(i_out_ch.header_length));
        end
    endtask

    // results are checked before the same edge's byte is queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            owed_results.delete();
        end else begin
            if (i_out_ch.valid && i_out_ch.ready) check_result();
            if (i_in_ch.valid && i_in_ch.ready) take_byte(i_in_ch.data_byte, i_in_ch.restart);
        end
        o_fail_count <= fail_total;
        o_pending    <= owed_results.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Feeds header bytes to the frame header parser: a short directed set of
// headers covering each error code and the held states, then random headers,
// truncated headers and loose bytes, under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import wsfh_pkg::*;

    // opcodes used to build frames
    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    localparam int MAX_HDR      = 14;
    localparam int TAIL_CYCLES  = 6;
    localparam int RANDOM_ITEMS = 1800;

    typedef enum int {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } t_idle;

    logic  i_clk;
    logic  i_rst_n;
    int    fail_count;
    int    pending;
    t_idle send_mode;
    t_idle recv_mode;
    int    sent_items;

    wsfh_in_if  in_ch ();
    wsfh_out_if out_ch ();

    websocket_frame_header_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    wsfh_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_500_000;
        $display("websocket_frame_header_parser verification failed");
        $finish;
    end

    function automatic int draw_wait(input t_idle mode);
        int w;
        case (mode)
            IDLE_NONE: w = 0;
            IDLE_FULL: w = $urandom_range(0, 15);
            default:   w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        endcase
        return w;
    endfunction

    // one byte request; returns at the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic rs);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.restart   <= rs;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // hold off until every owed result has been checked
    task automatic wait_drained;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // build a header and send its first 'cut' bytes
    task automatic send_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                               input logic mask, input logic [6:0] len_code,
                               input logic [63:0] ext_len, input logic [31:0] key,
                               input logic first_restart, input int cut);
        logic [7:0] hdr [MAX_HDR];
        int         n;
        hdr[0] = {fin, rsv, op};
        hdr[1] = {mask, len_code};
        n      = 2;
        if (len_code == LEN16_CODE) begin
            hdr[2] = ext_len[15:8];
            hdr[3] = ext_len[7:0];
            n      = 4;
        end else if (len_code == LEN64_CODE) begin
            for (int i = 0; i < 8; i++) hdr[2 + i] = ext_len[63 - 8 * i -: 8];
            n = 10;
        end
        if (mask) begin
            for (int i = 0; i < 4; i++) hdr[n + i] = key[31 - 8 * i -: 8];
            n = n + 4;
        end
        if (cut < n) n = cut;
        for (int i = 0; i < n; i++) send_byte(hdr[i], (i == 0) ? first_restart : 1'b0);
        sent_items += n;
    endtask

    // mostly well-formed frames; 'wild' draws byte 0 and the length code freely
    task automatic random_frame(input logic wild, input int cut);
        logic        fin;
        logic        mask;
        logic [2:0]  rsv;
        logic [3:0]  op;
        logic [6:0]  len_code;
        logic [63:0] ext_len;
        if (wild) begin
            {fin, rsv, op} = 8'($urandom);
            len_code       = 7'($urandom);
        end else begin
            case ($urandom_range(0, 6))
                0:       op = OP_CONT;
                1:       op = OP_TEXT;
                2:       op = OP_BINARY;
                3:       op = OP_CLOSE;
                4:       op = OP_PING;
                5:       op = OP_PONG;
                default: op = 4'($urandom);
            endcase
            rsv = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
            fin = (op[3] && $urandom_range(0, 9) != 0) ? 1'b1 : 1'($urandom);
            // control frames mostly keep to short lengths
            case ((op[3] && $urandom_range(0, 9) != 0) ? 0 : $urandom_range(0, 2))
                0: begin
                    case ($urandom_range(0, 5))
                        0:       len_code = 7'd0;
                        1:       len_code = CTRL_MAX;
                        default: len_code = 7'($urandom_range(0, 125));
                    endcase
                end
                1:       len_code = LEN16_CODE;
                default: len_code = LEN64_CODE;
            endcase
        end
        mask = 1'($urandom);

        // extended lengths lean on the minimal-encoding boundaries
        if (len_code == LEN16_CODE) begin
            case ($urandom_range(0, 7))
                0:       ext_len = 64'($urandom_range(0, 125));
                1:       ext_len = 64'(CTRL_MAX);
                2:       ext_len = 64'(LEN16_CODE);
                3:       ext_len = 64'hFFFF;
                default: ext_len = 64'($urandom_range(126, 65535));
            endcase
        end else begin
            case ($urandom_range(0, 7))
                0:       ext_len = 64'($urandom_range(0, 65535));
                1:       ext_len = 64'hFFFF;
                2:       ext_len = 64'h1_0000;
                3:       ext_len = '1;
                default: ext_len = {$urandom, $urandom};
            endcase
        end
        send_header(fin, rsv, op, mask, len_code, ext_len, $urandom, 1'b1, cut);
    endtask

    // stimulus
    initial begin
        int pick;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'd0;
        in_ch.restart   <= 1'b0;
        send_mode        = IDLE_NONE;
        sent_items       = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // masked text frame with no restart after reset, then an ignored byte
        send_header(1'b1, 3'd0, OP_TEXT, 1'b1, 7'd5, 64'd0, 32'hA1B2_C3D4, 1'b0, MAX_HDR);
        send_byte(8'h00, 1'b0);
        // 16-bit length below 126, error then held over a byte
        send_header(1'b0, 3'd0, OP_BINARY, 1'b0, LEN16_CODE, 64'(CTRL_MAX), 32'd0, 1'b1,
                    MAX_HDR);
        send_byte(8'hFF, 1'b0);
        // every basic check but the reserved opcode fails at once: oversize control wins
        send_header(1'b0, 3'b111, OP_PING, 1'b1, LEN16_CODE, 64'd0, 32'd0, 1'b1, 2);
        // reserved bits beat reserved opcode and fragmented control
        send_header(1'b0, 3'b111, OP_RSV_HI_FIRST, 1'b0, 7'd0, 64'd0, 32'd0, 1'b1, 2);
        send_header(1'b1, 3'd0, OP_RSV_LO_FIRST, 1'b0, 7'd0, 64'd0, 32'd0, 1'b1, 2);
        send_header(1'b0, 3'd0, OP_CLOSE, 1'b0, 7'd0, 64'd0, 32'd0, 1'b1, 2);
        // 64-bit length with the top bit set passes
        send_header(1'b1, 3'd0, OP_BINARY, 1'b0, LEN64_CODE, 64'h8000_0000_0000_FFFF,
                    32'd0, 1'b1, MAX_HDR);
        wait_drained();

        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 47) == 0) send_mode = t_idle'($urandom_range(0, 2));
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                random_frame(1'b0, MAX_HDR);
                // bytes after the header are ignored until restart
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            end else if (pick < 80) begin
                random_frame(1'b0, $urandom_range(1, 9));
            end else if (pick < 90) begin
                random_frame(1'b1, MAX_HDR);
            end else if (pick < 99) begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
                    sent_items++;
                end
            end else begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("websocket_frame_header_parser verification clean");
        end else begin
            $display("websocket_frame_header_parser verification failed");
        end
        $finish;
    end

    // result side back-pressure
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        recv_mode     = IDLE_FULL;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 47) == 0) recv_mode = t_idle'($urandom_range(0, 2));
            stall = draw_wait(recv_mode);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

endmodule

### files.f
src/wsfh_pkg.sv
src/wsfh_if.sv
src/wsfh_in_reg.sv
src/wsfh_parse.sv
src/wsfh_out_reg.sv
src/websocket_frame_header_parser.sv
bench/wsfh_checker.sv
bench/tb.sv
